// File: src/bmf3_pkg.sv
// Shared constants, register codes and helpers for the 3x3 binary majority filter.
// No dependencies; imported by binary_majority_filter_3x3.
`timescale 1ns / 1ps
`default_nettype none

package bmf3_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned WINDOW_W    = 9;

  localparam int unsigned MIN_SIZE    = 3;
  localparam int unsigned RESET_SIZE  = 4096;
  localparam int unsigned RESET_COUNT = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_MAJORITY_COUNT = 2'd2
  } cfg_reg_e;

  // Control that travels with a beat from the address stage to the update stage.
  typedef struct packed {
    logic px;
    logic emit;
    logic interior;
    logic last;
  } s1_ctl_t;

  function automatic logic [COUNT_W-1:0] popcount9(input logic [WINDOW_W-1:0] w);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WINDOW_W; i++) begin
      n = n + COUNT_W'(w[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/binary_majority_filter_3x3.sv
// Top level of the 3x3 binary majority filter: position control, row history memory,
// window and output register. Depends on bmf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The filter takes one pixel beat per clock and gives at most one result beat per clock.
// Each result is the majority of a 3x3 window (count of ones at least majority_count);
// pixels on the frame border come out as 0. Results lag the input stream by
// frame_width+1 beats, so frame_width+1 padding beats must follow each frame. Inside, a
// beat first reads the two-row history of its column from a MAX_WIDTH x 2 bit memory,
// then updates the window and writes the history back; the output register then holds
// the result. The input stalls after reset and after every configuration write while
// the pixel count of the frame is recomputed. It also stalls while the update stage
// holds a beat that cannot move on because the output register is full and stalled.
// No clearing pass is needed after reset.
module binary_majority_filter_3x3
  import bmf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Pixel input
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   pixel_in_i,
  input  wire logic                   is_padding_i,
  // Filtered output
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        pixel_out_o,
  output logic                        frame_last_o,
  // Configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned SZW_W = COL_W + 1;
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT) + 1;
  localparam int unsigned OUT_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
  localparam int unsigned TOT_W = OUT_W + 1;
  localparam int unsigned PRD_W = SZW_W + ROW_W;
  localparam int unsigned W_RST = (RESET_SIZE > MAX_WIDTH)  ? MAX_WIDTH  : RESET_SIZE;
  localparam int unsigned H_RST = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE;

  // Configuration, stored already clamped.
  logic [SZW_W-1:0]   width_q, width_d;
  logic [ROW_W-1:0]   height_q, height_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               cfg_busy_q;
  logic               cfg_acc;
  logic [TOT_W-1:0]   total_q;
  logic [PRD_W-1:0]   prod;

  // Position state.
  logic [COL_W-1:0] col_pos_q, col_pos_d;
  logic [ROW_W-1:0] row_pos_q, row_pos_d;
  logic [OUT_W-1:0] out_pos_q, out_pos_d;

  // Address stage.
  logic             in_acc;
  logic             wrap;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [SZW_W-1:0] col_next;
  s1_ctl_t          ctl_cur;

  // Update stage.
  logic             s1_valid_q;
  s1_ctl_t          s1_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_go;
  logic             s1_write;
  logic [1:0]       rd_q;
  logic             fwd_q;
  logic [1:0]       fwd_data_q;
  logic [1:0]       hist;
  logic [1:0]       hist_wr;
  logic [WINDOW_W-1:0] window_q;
  logic [WINDOW_W-1:0] win_shift;
  logic             result;

  logic [1:0] hist_mem [MAX_WIDTH];

  // Output register.
  logic out_valid_q;
  logic pixel_out_q;
  logic frame_last_q;

  // ---------------------------------------------------------------- configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    count_d  = count_q;
    if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH: begin
          if (32'(cfg_data_i) < MIN_SIZE) begin
            width_d = SZW_W'(MIN_SIZE);
          end else if (32'(cfg_data_i) > MAX_WIDTH) begin
            width_d = SZW_W'(MAX_WIDTH);
          end else begin
            width_d = SZW_W'(cfg_data_i);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (32'(cfg_data_i) < MIN_SIZE) begin
            height_d = ROW_W'(MIN_SIZE);
          end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
            height_d = ROW_W'(MAX_HEIGHT);
          end else begin
            height_d = ROW_W'(cfg_data_i);
          end
        end
        REG_MAJORITY_COUNT: begin
          count_d = cfg_data_i[COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign prod = {{ROW_W{1'b0}}, width_q} * {{SZW_W{1'b0}}, height_q};

  // The pixel count is registered; the input is held off while it is recomputed.
  always_ff @(posedge clk_i) begin
    total_q <= prod[TOT_W-1:0];
  end

  // ---------------------------------------------------------------- address stage
  assign s1_go      = ~out_valid_q | ~out_stall_i;
  assign s1_write   = s1_valid_q & s1_go;
  assign in_stall_o = cfg_busy_q | (s1_valid_q & ~s1_go);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    // A column left beyond a narrowed width wraps to the next row.
    wrap    = {1'b0, col_pos_q} >= width_q;
    col_cur = wrap ? '0 : col_pos_q;
    row_cur = wrap ? row_pos_q + ROW_W'(1) : row_pos_q;

    ctl_cur.px       = pixel_in_i & ~is_padding_i;
    ctl_cur.emit     = (row_cur >= ROW_W'(2)) || (row_cur == ROW_W'(1) && col_cur != '0);
    ctl_cur.interior = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2)) &&
                       (row_cur < height_q);
    ctl_cur.last     = ctl_cur.emit && ({1'b0, out_pos_q} >= total_q - TOT_W'(1));

    col_next = SZW_W'(col_cur) + SZW_W'(1);
    if (col_next >= width_q) begin
      col_pos_d = '0;
      row_pos_d = row_cur + ROW_W'(1);
    end else begin
      col_pos_d = col_next[COL_W-1:0];
      row_pos_d = row_cur;
    end

    out_pos_d = out_pos_q;
    if (ctl_cur.emit) begin
      out_pos_d = out_pos_q + OUT_W'(1);
    end

    if (ctl_cur.last) begin
      col_pos_d = '0;
      row_pos_d = '0;
      out_pos_d = '0;
    end
  end

  // ---------------------------------------------------------------- history memory
  always_ff @(posedge clk_i) begin
    if (s1_write) begin
      hist_mem[s1_col_q] <= hist_wr;
    end
    if (in_acc) begin
      rd_q <= hist_mem[col_cur];
    end
  end

  // ---------------------------------------------------------------- update stage
  // A read that meets the write of the same column in the same cycle takes the new value.
  assign hist      = fwd_q ? fwd_data_q : rd_q;
  assign hist_wr   = {hist[0], s1_q.px};
  assign win_shift = {window_q[WINDOW_W-4:0], hist, s1_q.px};
  assign result    = s1_q.interior && (popcount9(win_shift) >= count_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q       <= ctl_cur;
      s1_col_q   <= col_cur;
      fwd_data_q <= hist_wr;
    end
    if (s1_write && s1_q.emit) begin
      pixel_out_q  <= result;
      frame_last_q <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= SZW_W'(W_RST);
      height_q    <= ROW_W'(H_RST);
      count_q     <= COUNT_W'(RESET_COUNT);
      cfg_busy_q  <= 1'b1;
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      out_pos_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      count_q    <= count_d;
      cfg_busy_q <= cfg_acc;

      if (in_acc) begin
        col_pos_q  <= col_pos_d;
        row_pos_q  <= row_pos_d;
        out_pos_q  <= out_pos_d;
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_write && (s1_col_q == col_cur);
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_write) begin
        window_q <= s1_q.last ? '0 : win_shift;
      end

      if (s1_write && s1_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign frame_last_o = frame_last_q;

endmodule

`default_nettype wire

// File: tb/majority_window_checker.sv
// Checker for the 3x3 binary majority filter: watches the pixel, result and register
// channels, predicts every filtered pixel and compares it with the block's output.
// Depends on bmf3_pkg.
`timescale 1ns / 1ps

module majority_window_checker
  import bmf3_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   pixel_in_i,
  input  logic                   is_padding_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic                   pixel_out_i,
  input  logic                   frame_last_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     mismatch_count_o,
  output int                     outstanding_o,
  output int                     results_checked_o,
  output logic                   frame_open_o
);

  localparam int unsigned LINE_W = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H  = DEF_MAX_HEIGHT;

  typedef struct packed {
    logic pixel;
    logic last;
  } filtered_px_t;

  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;
  logic [COUNT_W-1:0]    threshold_q;
  logic [1:0]            line_hist [LINE_W];
  logic [WINDOW_W-1:0]   window_q;
  int unsigned           col_q;
  int unsigned           row_q;
  int unsigned           opos_q;
  int                    mismatches;
  int                    checked;
  filtered_px_t          pending_pixels [$];
  filtered_px_t          want;

  // Moves the window on by one beat and queues the filtered pixel that it releases.
  task automatic slide_window(input logic raw_px, input logic pad);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    logic         px;
    logic [1:0]   hist;
    logic [2:0]   column;
    filtered_px_t res;
    w = (width_q < MIN_SIZE) ? MIN_SIZE : ((width_q > LINE_W) ? LINE_W : width_q);
    h = (height_q < MIN_SIZE) ? MIN_SIZE : ((height_q > MAX_H) ? MAX_H : height_q);
    px = raw_px & ~pad;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
    c = col_q;
    r = row_q;
    hist = line_hist[c];
    column = {hist, px};
    line_hist[c] = {hist[0], px};
    window_q = {window_q[5:0], column};
    col_q = c + 1;
    if (col_q >= w) begin
      col_q = 0;
      row_q = r + 1;
    end
    // Nothing comes out until a row and one pixel have gone in.
    if (r >= 2 || (r == 1 && c >= 1)) begin
      res.pixel = (c >= 2) && (r >= 2) && (r <= h - 1) &&
                  ($countones(window_q) >= threshold_q);
      res.last = (opos_q >= w * h - 1);
      pending_pixels.push_back(res);
      if (res.last) begin
        opos_q = 0;
        col_q = 0;
        row_q = 0;
        window_q = '0;
      end else begin
        opos_q = (opos_q + 1) & 32'hFF_FFFF;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q = CFG_DATA_W'(RESET_SIZE);
      height_q = CFG_DATA_W'(RESET_SIZE);
      threshold_q = COUNT_W'(RESET_COUNT);
      for (int k = 0; k < LINE_W; k++) line_hist[k] = 2'b00;
      window_q = '0;
      col_q = 0;
      row_q = 0;
      opos_q = 0;
      pending_pixels.delete();
      outstanding_o <= 0;
      frame_open_o <= 1'b0;
      mismatch_count_o <= mismatches;
      results_checked_o <= checked;
    end else begin
      // The result side is checked first so that a beat arriving with nothing
      // queued cannot match a prediction made on this same edge.
      if (out_valid_i && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: result beat with nothing expected: pixel_out=%0b frame_last=%0b",
                   $time, pixel_out_i, frame_last_i);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_out_i !== want.pixel) begin
            $display("%0t: pixel_out expected %0b, got %0b", $time, want.pixel,
                     pixel_out_i);
            mismatches++;
          end
          if (frame_last_i !== want.last) begin
            $display("%0t: frame_last expected %0b, got %0b", $time, want.last,
                     frame_last_i);
            mismatches++;
          end
          checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_WIDTH:    width_q = cfg_data_i;
          REG_FRAME_HEIGHT:   height_q = cfg_data_i;
          REG_MAJORITY_COUNT: threshold_q = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) slide_window(pixel_in_i, is_padding_i);
      outstanding_o <= pending_pixels.size();
      frame_open_o <= (col_q != 0) || (row_q != 0) || (opos_q != 0);
      mismatch_count_o <= mismatches;
      results_checked_o <= checked;
    end
  end

endmodule

// File: tb/tb_binary_majority_filter_3x3.sv
// Testbench top for the 3x3 binary majority filter: clock, reset, pixel and register
// stimulus, receiver stalls and the verdict. Depends on bmf3_pkg,
// binary_majority_filter_3x3 and majority_window_checker.
`timescale 1ns / 1ps

module tb_binary_majority_filter_3x3;
  import bmf3_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int unsigned {
    SEQ_CLEAN,
    SEQ_INNER_PAD,
    SEQ_SURPLUS,
    SEQ_SHORT_PAD,
    SEQ_LONG_PAD,
    SEQ_NOISE
  } seq_kind_e;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   pixel_in = 1'b0;
  logic                   padding = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   pixel_out;
  logic                   frame_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          mismatches;
  int          outstanding;
  int          results_checked;
  logic        frame_open;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned settings_used = 0;
  int unsigned frame_w = RESET_SIZE;
  int unsigned frame_h = RESET_SIZE;
  bit          src_gaps = 1'b0;
  bit          sink_stalls = 1'b0;
  bit          hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  binary_majority_filter_3x3 dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_in_i   (pixel_in),
    .is_padding_i (padding),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_o  (pixel_out),
    .frame_last_o (frame_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  majority_window_checker watch (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .pixel_in_i        (pixel_in),
    .is_padding_i      (padding),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .pixel_out_i       (pixel_out),
    .frame_last_i      (frame_last),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatch_count_o  (mismatches),
    .outstanding_o     (outstanding),
    .results_checked_o (results_checked),
    .frame_open_o      (frame_open)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_binary_majority_filter_3x3: FAIL");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned eff_size(input logic [CFG_DATA_W-1:0] v,
                                           input int unsigned lim);
    return (v < MIN_SIZE) ? MIN_SIZE : ((v > lim) ? lim : v);
  endfunction

  initial begin : result_sink
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic px, input logic pad);
    in_valid <= 1'b1;
    pixel_in <= px;
    padding <= pad;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Waits for every predicted pixel, then for the pipeline to empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Feeds padding beats until the filter is back at the start of a frame.
  task automatic close_frame();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_open) begin
      send_item(1'($urandom_range(0, 1)), 1'b1);
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic program_filter(input logic [CFG_DATA_W-1:0] wdata,
                                input logic [CFG_DATA_W-1:0] hdata,
                                input logic [COUNT_W-1:0]    cnt);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  val [4];
    int unsigned            n;
    idx[0] = REG_FRAME_WIDTH;
    idx[1] = REG_FRAME_HEIGHT;
    idx[2] = REG_MAJORITY_COUNT;
    idx[3] = REG_SPARE;
    val[0] = wdata;
    val[1] = hdata;
    // Bits above the count are junk that the block must ignore.
    val[2] = CFG_DATA_W'(($urandom << COUNT_W) | cnt);
    val[3] = CFG_DATA_W'($urandom);
    n = ($urandom_range(0, 3) == 0) ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    frame_w = eff_size(wdata, DEF_MAX_WIDTH);
    frame_h = eff_size(hdata, DEF_MAX_HEIGHT);
    settings_used++;
  endtask

  task automatic send_frame(input seq_kind_e kind, input int unsigned density,
                            input int hold_at);
    int unsigned npix;
    int unsigned npad;
    logic        px;
    logic        pad;
    npix = frame_w * frame_h;
    npad = frame_w + 1;
    if (kind == SEQ_SHORT_PAD) npad = $urandom_range(0, frame_w);
    if (kind == SEQ_LONG_PAD) npad = frame_w + 1 + $urandom_range(1, 2 * frame_w);
    for (int i = 0; i < npix + npad; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      px = ($urandom_range(0, 99) < density);
      pad = (i >= npix);
      case (kind)
        SEQ_INNER_PAD: if (!pad) pad = ($urandom_range(0, 7) == 0);
        SEQ_SURPLUS:   if (pad) pad = ($urandom_range(0, 2) != 0);
        SEQ_NOISE:     pad = 1'($urandom_range(0, 1));
        default: ;
      endcase
      if (pad) px = 1'($urandom_range(0, 1));
      send_item(px, pad);
    end
    frames_sent++;
  endtask

  initial begin : stimulus
    int unsigned   base;
    int unsigned   pick;
    logic [12:0]   wdata;
    logic [12:0]   hdata;
    logic [3:0]    cnt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A solid frame, whose flush beats carry ones that must be dropped.
    program_filter(13'd3, 13'd3, 4'd5);
    for (int i = 0; i < 13; i++) send_item(1'b1, i >= 9);
    // A centre padding beat counts as 0, leaving four ones in the window;
    // then real pixels stand where the flush beats belong.
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    repeat (4) send_item(1'b1, 1'b0);
    frames_sent += 2;
    settle();

    // A wider frame, with the receiver holding off once results are flowing.
    sink_stalls = 1'b1;
    program_filter(13'd40, 13'd6, 4'd9);
    send_frame(SEQ_CLEAN, 85, 50);
    settle();
    // A narrow, taller frame from a zero width register, with a zero count.
    program_filter(13'd0, 13'd20, 4'd0);
    send_frame(SEQ_CLEAN, 30, -1);
    settle();
    // Undersized registers clamp; counts above nine give all zeros.
    src_gaps = 1'b1;
    program_filter(13'd2, 13'd0, 4'd15);
    send_frame(SEQ_CLEAN, 90, -1);
    send_frame(SEQ_CLEAN, 50, -1);
    settle();
    program_filter(13'd1, 13'd2, 4'd10);
    send_frame(SEQ_INNER_PAD, 80, -1);
    settle();

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      close_frame();
      settle();
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      wdata = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 12));
      hdata = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 10));
      cnt = COUNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(3, 7));
      program_filter(wdata, hdata, cnt);
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 10);
        send_frame((pick < 6) ? SEQ_CLEAN : seq_kind_e'(pick - 5), $urandom_range(5, 95),
                   ($urandom_range(0, 19) == 0) ? int'(frame_w + 3) : -1);
        if ($urandom_range(0, 3) == 0) settle();
      end
    end
    close_frame();
    settle();

    $display("Run covered %0d pixel beats in %0d frames over %0d register settings,",
             items_sent, frames_sent, settings_used);
    $display("with %0d filtered pixels compared and %0d mismatches.", results_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("tb_binary_majority_filter_3x3: PASS");
    end else begin
      $display("tb_binary_majority_filter_3x3: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bmf3_pkg.sv
src/binary_majority_filter_3x3.sv
tb/majority_window_checker.sv
tb/tb_binary_majority_filter_3x3.sv
